// ----- rtl/srt_pkg.sv -----
// ---------------------------------------------------------------------------
// srt_pkg - shared definitions for the sort engine
// Element width and the command and status groups between the controller
// and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

   localparam int DATA_W = 32;

   typedef struct packed {
      logic insert;     // store the incoming element in order
      logic shift_down; // move every cell one place toward cell 0
      logic shift_up;   // move every cell one place toward the top cell
      logic clear;      // empty the store and drop the overflow mark
      logic dir_up;     // present the top cell instead of cell 0
   } cmd_type;

   typedef struct packed {
      logic full;       // every cell holds an element
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/sort_engine.sv -----
// ---------------------------------------------------------------------------
// sort_engine - insertion sort of a set of signed 32-bit elements
// Collects a set closed by tlast and returns it sorted, ascending or
// descending by the order register, with the overflow mark on every result.
//
//   channel  direction  payload
//   req_     in         tdata = value[31:0], tlast = last_of_set
//   rsp_     out        tdata = sorted_value[31:0], tlast = last_result,
//                       tuser = overflow
//   csr_     in         csr_data = ascending
//
// While collecting, the insert cell chain places each element in order as it
// arrives. After the closing element, descending order first aligns the set
// to the top cell, then the results follow one per cycle while rsp_tready is
// high, as the chain shifts. Input is held off from the closing
// transaction until the final result is taken. Reset clears control only; the
// cells need no clearing pass. Output stalls freeze the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module sort_engine #(
   parameter int MAX_ELEMS = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [srt_pkg::DATA_W-1:0]       req_tdata,  // value[31:0]
   input  wire                              req_tlast,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [srt_pkg::DATA_W-1:0]       rsp_tdata,  // sorted_value[31:0]
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,  // overflow
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire                              csr_data
);

   localparam int CNT_W = $clog2(MAX_ELEMS + 1);

   srt_pkg::cmd_type                  cmd;
   srt_pkg::status_type               status;
   logic [CNT_W-1:0]                  count;
   logic signed [srt_pkg::DATA_W-1:0] out_value;

   srt_ctrl #(
      .MAX_ELEMS (MAX_ELEMS),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .count      (count)
   );

   srt_datapath #(
      .MAX_ELEMS (MAX_ELEMS),
      .CNT_W     (CNT_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .value     ($signed(req_tdata)),
      .status    (status),
      .count     (count),
      .out_value (out_value),
      .dropped   (rsp_tuser)
   );

   assign rsp_tdata = $unsigned(out_value);

endmodule

`default_nettype wire

// ----- rtl/srt_datapath.sv -----
// ---------------------------------------------------------------------------
// srt_datapath - chain of compare-and-insert cells
// Keeps the stored elements in ascending order at all times, holds the fill
// count and overflow mark, and shifts the set out in either direction.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_datapath #(
   parameter int MAX_ELEMS = 32,
   parameter int CNT_W     = $clog2(MAX_ELEMS + 1)
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  srt_pkg::cmd_type                    cmd,
   input  wire  signed [srt_pkg::DATA_W-1:0]   value,
   output srt_pkg::status_type                 status,
   output logic [CNT_W-1:0]                    count,
   output logic signed [srt_pkg::DATA_W-1:0]   out_value,
   output logic                                dropped
);

   logic signed [srt_pkg::DATA_W-1:0] cell_ff [MAX_ELEMS];
   logic signed [srt_pkg::DATA_W-1:0] cell_in [MAX_ELEMS];
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              dropped_ff, dropped_in;
   logic [MAX_ELEMS-1:0]              ins;
   logic                              full;

   assign full = (count_ff == CNT_W'(MAX_ELEMS));

   genvar g;
   generate
      for (g = 0; g < MAX_ELEMS; g++) begin : g_cell
         logic                              ins_prev;
         logic signed [srt_pkg::DATA_W-1:0] below;
         logic signed [srt_pkg::DATA_W-1:0] above;

         assign ins[g] = ((CNT_W'(g) < count_ff) && (cell_ff[g] > value)) ||
                         (CNT_W'(g) == count_ff);

         if (g == 0) begin : g_first
            assign ins_prev = 1'b0;
            assign below    = cell_ff[g];
         end else begin : g_rest
            assign ins_prev = ins[g-1];
            assign below    = cell_ff[g-1];
         end

         if (g == MAX_ELEMS - 1) begin : g_top
            assign above = cell_ff[g];
         end else begin : g_mid
            assign above = cell_ff[g+1];
         end

         always_comb begin
            cell_in[g] = cell_ff[g];
            if (cmd.insert && !full && ins[g]) begin
               cell_in[g] = ins_prev ? below : value;
            end else if (cmd.shift_down) begin
               cell_in[g] = above;
            end else if (cmd.shift_up) begin
               cell_in[g] = below;
            end
         end

         always_ff @(posedge clock) begin
            cell_ff[g] <= cell_in[g];
         end
      end
   endgenerate

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.insert) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign status.full = full;
   assign count       = count_ff;
   assign dropped     = dropped_ff;
   assign out_value   = cmd.dir_up ? cell_ff[MAX_ELEMS-1] : cell_ff[0];

endmodule

`default_nettype wire

// ----- rtl/srt_ctrl.sv -----
// ---------------------------------------------------------------------------
// srt_ctrl - sort engine controller
// Collects elements, aligns the set to the top cell for descending order and
// sequences the output run; holds the order register.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_ctrl #(
   parameter int MAX_ELEMS = 32,
   parameter int CNT_W     = $clog2(MAX_ELEMS + 1)
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire                  req_tlast,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic                 rsp_tlast,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire                  csr_data,
   output srt_pkg::cmd_type     cmd,
   input  srt_pkg::status_type  status,
   input  wire  [CNT_W-1:0]     count
);

   typedef enum logic [2:0] {
      COLLECT = 3'b001,
      ALIGN   = 3'b010,
      EMIT    = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             ascending_ff, ascending_in;
   logic [CNT_W-1:0] set_size;

   assign set_size = status.full ? count : count + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      remain_in    = remain_ff;
      ascending_in = ascending_ff;
      cmd          = '0;
      cmd.dir_up   = !ascending_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      rsp_tlast    = (remain_ff == CNT_W'(1));

      if (csr_valid) begin
         ascending_in = csr_data;
      end

      unique case (state_ff)
         COLLECT: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.insert = 1'b1;
               if (req_tlast) begin
                  remain_in = set_size;
                  pos_in    = set_size;
                  if (ascending_ff || set_size == CNT_W'(MAX_ELEMS)) begin
                     state_in = EMIT;
                  end else begin
                     state_in = ALIGN;
                  end
               end
            end
         end
         ALIGN: begin
            cmd.shift_up = 1'b1;
            pos_in       = pos_ff + CNT_W'(1);
            if (pos_ff == CNT_W'(MAX_ELEMS - 1)) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.shift_down = ascending_ff;
               cmd.shift_up   = !ascending_ff;
               remain_in      = remain_ff - CNT_W'(1);
               if (rsp_tlast) begin
                  cmd.clear = 1'b1;
                  state_in  = COLLECT;
               end
            end
         end
         default: begin
            state_in = COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= COLLECT;
         pos_ff       <= '0;
         remain_ff    <= '0;
         ascending_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         remain_ff    <= remain_in;
         ascending_ff <= ascending_in;
      end
   end

   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/srt_checker.sv -----
// ---------------------------------------------------------------------------
// srt_checker - port-level checks for the sort engine
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_tready,
   input wire                         rsp_tvalid,
   input wire                         rsp_tready,
   input wire [srt_pkg::DATA_W-1:0]   rsp_tdata,
   input wire                         rsp_tlast,
   input wire                         rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not ready for input after reset");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results pending");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("run did not end on final result");

   a_flag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tuser == $past(rsp_tuser))
      else $error("overflow mark changed inside a run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind sort_engine srt_checker u_srt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
